FILE: hw/rtl/psr_pkg.sv
// ---------------------------------------------------------------------------
// psr_pkg
// Shared types and constants of the five-point Poisson relaxation engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psr_pkg;

  // grid geometry and number formats
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int CELLS     = 1 << ADDR_W;
  localparam int MAX_ROWS  = 1 << ROW_W;
  localparam int MAX_COLS  = 1 << COL_W;
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 24;
  localparam int WGT_W     = 25;
  localparam int RES_W     = 31;
  localparam int CNT_W     = 16;
  localparam int DIM_W     = 7;
  localparam int MODE_W    = 1;

  // configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_ROWS = 3'd0,
    REG_COLS = 3'd1,
    REG_WH   = 3'd2,
    REG_WV   = 3'd3,
    REG_WS   = 3'd4,
    REG_TOL  = 3'd5,
    REG_MAXI = 3'd6,
    REG_MODE = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_SOLVE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [0:0] {
    MODE_JACOBI = 1'b0,
    MODE_GAUSS  = 1'b1
  } mode_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_L,
    ST_R,
    ST_U,
    ST_D,
    ST_C,
    ST_MUL,
    ST_ADD,
    ST_RND,
    ST_WB,
    ST_MAX,
    ST_CP_RD,
    ST_CP_WR,
    ST_CHECK,
    ST_DONE
  } state_t;

  // datapath step per cycle of one cell update
  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_LEFT,
    STEP_RIGHT,
    STEP_UP,
    STEP_DOWN,
    STEP_MUL,
    STEP_ADD,
    STEP_RND,
    STEP_DIFF,
    STEP_MAX
  } step_t;

  typedef enum logic [1:0] {
    WS_INPUT,
    WS_RELAX,
    WS_COPY
  } wsel_t;

  typedef struct packed {
    step_t              step;
    logic [ADDR_W-1:0]  grid_raddr;
    logic [ADDR_W-1:0]  cell_addr;
    logic               grid_we;
    wsel_t              grid_wsel;
    logic               next_we;
    logic               src_we;
    logic               worst_clr;
    logic               status_ld;
    logic [CNT_W-1:0]   sweeps;
    logic               out_ld;
    logic               out_rd;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic within_tol;
  } stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/poisson_stencil_relaxation_top.sv
// ---------------------------------------------------------------------------
// poisson_stencil_relaxation_top
// Five-point Poisson relaxation engine with APB-style configuration.
// ---------------------------------------------------------------------------
// A write-cell word is stored as it is taken, a read-cell word goes through
// ST_READ; one result word comes back for every input word.
// A solve word runs sweeps over the interior of the grid: each interior cell
// steps through the states ST_L to ST_MAX, as its four neighbours and its
// old value are fetched one after another through the single read port of
// the grid memory, and a Jacobi sweep adds a copy pass through ST_CP_RD and
// ST_CP_WR per interior cell; each sweep ends in ST_CHECK, and the result
// is loaded in ST_DONE after the last sweep. No input word is taken while a
// solve runs or while a result waits on a stalled output.
`timescale 1ns / 1ps
`default_nettype none

module poisson_stencil_relaxation_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input words
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_req_type,
  input  wire logic [psr_pkg::ROW_W-1:0]          in_row_index,
  input  wire logic [psr_pkg::COL_W-1:0]          in_col_index,
  input  wire logic signed [psr_pkg::DATA_W-1:0]  in_cell_value,
  input  wire logic signed [psr_pkg::DATA_W-1:0]  in_source_term,
  // result words
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [psr_pkg::DATA_W-1:0]       out_read_value,
  output logic [psr_pkg::CNT_W-1:0]               out_iterations_done,
  output logic                                    out_converged,
  output logic [psr_pkg::RES_W-1:0]               out_residual,
  // configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [psr_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [psr_pkg::PDATA_W-1:0]        pwdata,
  output logic [psr_pkg::PDATA_W-1:0]             prdata,
  output logic                                    pready
);

  logic [psr_pkg::DIM_W-1:0]  rows_r, cols_r;
  logic [psr_pkg::WGT_W-1:0]  wh_r, wv_r, ws_r;
  logic [psr_pkg::RES_W-1:0]  tol_r;
  logic [psr_pkg::CNT_W-1:0]  maxi_r;
  logic [psr_pkg::MODE_W-1:0] mode_r;

  psr_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  psr_pkg::cmd_t  cmd;
  psr_pkg::stat_t stat;

  assign pready  = 1'b1;
  assign reg_idx = psr_pkg::reg_idx_t'(paddr[psr_pkg::PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= psr_pkg::DIM_W'(64);
      cols_r <= psr_pkg::DIM_W'(64);
      wh_r   <= psr_pkg::WGT_W'(4194304);
      wv_r   <= psr_pkg::WGT_W'(4194304);
      ws_r   <= '0;
      tol_r  <= '0;
      maxi_r <= psr_pkg::CNT_W'(10);
      mode_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        psr_pkg::REG_ROWS: rows_r <= pwdata[psr_pkg::DIM_W-1:0];
        psr_pkg::REG_COLS: cols_r <= pwdata[psr_pkg::DIM_W-1:0];
        psr_pkg::REG_WH:   wh_r   <= pwdata[psr_pkg::WGT_W-1:0];
        psr_pkg::REG_WV:   wv_r   <= pwdata[psr_pkg::WGT_W-1:0];
        psr_pkg::REG_WS:   ws_r   <= pwdata[psr_pkg::WGT_W-1:0];
        psr_pkg::REG_TOL:  tol_r  <= pwdata[psr_pkg::RES_W-1:0];
        psr_pkg::REG_MAXI: maxi_r <= pwdata[psr_pkg::CNT_W-1:0];
        psr_pkg::REG_MODE: mode_r <= pwdata[psr_pkg::MODE_W-1:0];
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      psr_pkg::REG_ROWS: prdata = psr_pkg::PDATA_W'(rows_r);
      psr_pkg::REG_COLS: prdata = psr_pkg::PDATA_W'(cols_r);
      psr_pkg::REG_WH:   prdata = psr_pkg::PDATA_W'(wh_r);
      psr_pkg::REG_WV:   prdata = psr_pkg::PDATA_W'(wv_r);
      psr_pkg::REG_WS:   prdata = psr_pkg::PDATA_W'(ws_r);
      psr_pkg::REG_TOL:  prdata = psr_pkg::PDATA_W'(tol_r);
      psr_pkg::REG_MAXI: prdata = psr_pkg::PDATA_W'(maxi_r);
      psr_pkg::REG_MODE: prdata = psr_pkg::PDATA_W'(mode_r);
    endcase
  end

  psr_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .grid_rows      (rows_r),
    .grid_cols      (cols_r),
    .max_iterations (maxi_r),
    .update_mode    (mode_r),
    .stat           (stat),
    .cmd            (cmd)
  );

  psr_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_cell_value       (in_cell_value),
    .in_source_term      (in_source_term),
    .weight_horizontal   (wh_r),
    .weight_vertical     (wv_r),
    .weight_source       (ws_r),
    .tolerance           (tol_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_value      (out_read_value),
    .out_iterations_done (out_iterations_done),
    .out_converged       (out_converged),
    .out_residual        (out_residual)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/psr_ram.sv
// ---------------------------------------------------------------------------
// psr_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/psr_ctrl.sv
// ---------------------------------------------------------------------------
// psr_ctrl
// Request sequencer: walks cells, sweeps and copy passes, issues datapath commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psr_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_req_type,
  input  wire logic [psr_pkg::ROW_W-1:0]   in_row_index,
  input  wire logic [psr_pkg::COL_W-1:0]   in_col_index,
  input  wire logic [psr_pkg::DIM_W-1:0]   grid_rows,
  input  wire logic [psr_pkg::DIM_W-1:0]   grid_cols,
  input  wire logic [psr_pkg::CNT_W-1:0]   max_iterations,
  input  wire logic [psr_pkg::MODE_W-1:0]  update_mode,
  input  wire psr_pkg::stat_t              stat,
  output psr_pkg::cmd_t                    cmd
);

  localparam logic [psr_pkg::DIM_W-1:0] ROWS_CAP = psr_pkg::DIM_W'(psr_pkg::MAX_ROWS);
  localparam logic [psr_pkg::DIM_W-1:0] COLS_CAP = psr_pkg::DIM_W'(psr_pkg::MAX_COLS);
  localparam logic [psr_pkg::DIM_W-1:0] MIN_DIM  = psr_pkg::DIM_W'(3);
  localparam logic [psr_pkg::DIM_W-1:0] TWO      = psr_pkg::DIM_W'(2);

  psr_pkg::state_t state_r, state_nxt;
  logic [psr_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [psr_pkg::COL_W-1:0] col_r, col_nxt;
  logic [psr_pkg::CNT_W-1:0] count_r, count_nxt;

  logic [psr_pkg::DIM_W-1:0] rows_eff, cols_eff, last_row, last_col;
  logic [psr_pkg::CNT_W-1:0] count_inc;
  logic                      no_interior, row_end, col_end, accept;

  // effective grid size and walk limits
  assign rows_eff    = (grid_rows > ROWS_CAP) ? ROWS_CAP : grid_rows;
  assign cols_eff    = (grid_cols > COLS_CAP) ? COLS_CAP : grid_cols;
  assign last_row    = rows_eff - TWO;
  assign last_col    = cols_eff - TWO;
  assign no_interior = (rows_eff < MIN_DIM) || (cols_eff < MIN_DIM);
  assign col_end     = ({1'b0, col_r} == last_col);
  assign row_end     = ({1'b0, row_r} == last_row);
  assign count_inc   = count_r + psr_pkg::CNT_W'(1);

  assign accept   = (state_r == psr_pkg::ST_IDLE) && in_valid && !stat.out_busy;
  assign in_stall = !((state_r == psr_pkg::ST_IDLE) && !stat.out_busy);

  // state and loop counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psr_pkg::ST_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      count_r <= count_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    count_nxt = count_r;

    cmd            = '0;
    cmd.step       = psr_pkg::STEP_NONE;
    cmd.grid_wsel  = psr_pkg::WS_RELAX;
    cmd.grid_raddr = {row_r, col_r};
    cmd.cell_addr  = {row_r, col_r};
    cmd.sweeps     = count_inc;

    unique case (state_r)
      psr_pkg::ST_IDLE: begin
        cmd.grid_raddr = {in_row_index, in_col_index};
        cmd.cell_addr  = {in_row_index, in_col_index};
        if (accept) begin
          unique case (psr_pkg::req_t'(in_req_type))
            psr_pkg::REQ_WRITE: begin
              cmd.grid_we   = 1'b1;
              cmd.grid_wsel = psr_pkg::WS_INPUT;
              cmd.src_we    = 1'b1;
              cmd.out_ld    = 1'b1;
            end
            psr_pkg::REQ_READ: begin
              state_nxt = psr_pkg::ST_READ;
            end
            psr_pkg::REQ_SOLVE: begin
              cmd.worst_clr = 1'b1;
              count_nxt     = '0;
              row_nxt       = psr_pkg::ROW_W'(1);
              col_nxt       = psr_pkg::COL_W'(1);
              state_nxt     = no_interior ? psr_pkg::ST_CHECK : psr_pkg::ST_L;
            end
            psr_pkg::REQ_NONE: begin
              cmd.out_ld = 1'b1;
            end
          endcase
        end
      end
      psr_pkg::ST_READ: begin
        cmd.out_ld = 1'b1;
        cmd.out_rd = 1'b1;
        state_nxt  = psr_pkg::ST_IDLE;
      end
      psr_pkg::ST_L: begin
        cmd.grid_raddr = {row_r, col_r - psr_pkg::COL_W'(1)};
        state_nxt      = psr_pkg::ST_R;
      end
      psr_pkg::ST_R: begin
        cmd.grid_raddr = {row_r, col_r + psr_pkg::COL_W'(1)};
        cmd.step       = psr_pkg::STEP_LEFT;
        state_nxt      = psr_pkg::ST_U;
      end
      psr_pkg::ST_U: begin
        cmd.grid_raddr = {row_r - psr_pkg::ROW_W'(1), col_r};
        cmd.step       = psr_pkg::STEP_RIGHT;
        state_nxt      = psr_pkg::ST_D;
      end
      psr_pkg::ST_D: begin
        cmd.grid_raddr = {row_r + psr_pkg::ROW_W'(1), col_r};
        cmd.step       = psr_pkg::STEP_UP;
        state_nxt      = psr_pkg::ST_C;
      end
      psr_pkg::ST_C: begin
        cmd.step  = psr_pkg::STEP_DOWN;
        state_nxt = psr_pkg::ST_MUL;
      end
      psr_pkg::ST_MUL: begin
        cmd.step  = psr_pkg::STEP_MUL;
        state_nxt = psr_pkg::ST_ADD;
      end
      psr_pkg::ST_ADD: begin
        cmd.step  = psr_pkg::STEP_ADD;
        state_nxt = psr_pkg::ST_RND;
      end
      psr_pkg::ST_RND: begin
        cmd.step  = psr_pkg::STEP_RND;
        state_nxt = psr_pkg::ST_WB;
      end
      psr_pkg::ST_WB: begin
        cmd.step = psr_pkg::STEP_DIFF;
        if (psr_pkg::mode_t'(update_mode) == psr_pkg::MODE_GAUSS) begin
          cmd.grid_we = 1'b1;
        end else begin
          cmd.next_we = 1'b1;
        end
        state_nxt = psr_pkg::ST_MAX;
      end
      psr_pkg::ST_MAX: begin
        cmd.step = psr_pkg::STEP_MAX;
        if (!col_end) begin
          col_nxt   = col_r + psr_pkg::COL_W'(1);
          state_nxt = psr_pkg::ST_L;
        end else begin
          col_nxt = psr_pkg::COL_W'(1);
          if (!row_end) begin
            row_nxt   = row_r + psr_pkg::ROW_W'(1);
            state_nxt = psr_pkg::ST_L;
          end else begin
            row_nxt   = psr_pkg::ROW_W'(1);
            state_nxt = (psr_pkg::mode_t'(update_mode) == psr_pkg::MODE_GAUSS) ?
                        psr_pkg::ST_CHECK : psr_pkg::ST_CP_RD;
          end
        end
      end
      // copy the new interior back into the grid after a Jacobi sweep
      psr_pkg::ST_CP_RD: begin
        state_nxt = psr_pkg::ST_CP_WR;
      end
      psr_pkg::ST_CP_WR: begin
        cmd.grid_we   = 1'b1;
        cmd.grid_wsel = psr_pkg::WS_COPY;
        state_nxt     = psr_pkg::ST_CP_RD;
        if (!col_end) begin
          col_nxt = col_r + psr_pkg::COL_W'(1);
        end else begin
          col_nxt = psr_pkg::COL_W'(1);
          if (!row_end) begin
            row_nxt = row_r + psr_pkg::ROW_W'(1);
          end else begin
            row_nxt   = psr_pkg::ROW_W'(1);
            state_nxt = psr_pkg::ST_CHECK;
          end
        end
      end
      psr_pkg::ST_CHECK: begin
        count_nxt = count_inc;
        if (stat.within_tol || (count_inc >= max_iterations)) begin
          cmd.status_ld = 1'b1;
          state_nxt     = psr_pkg::ST_DONE;
        end else begin
          cmd.worst_clr = 1'b1;
          state_nxt     = psr_pkg::ST_L;
        end
      end
      psr_pkg::ST_DONE: begin
        cmd.out_ld = 1'b1;
        state_nxt  = psr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = psr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/psr_dp.sv
// ---------------------------------------------------------------------------
// psr_dp
// Datapath: grid, source and next-grid memories, stencil arithmetic, status
// and output word register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psr_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire psr_pkg::cmd_t                     cmd,
  output psr_pkg::stat_t                         stat,
  input  wire logic signed [psr_pkg::DATA_W-1:0] in_cell_value,
  input  wire logic signed [psr_pkg::DATA_W-1:0] in_source_term,
  input  wire logic [psr_pkg::WGT_W-1:0]         weight_horizontal,
  input  wire logic [psr_pkg::WGT_W-1:0]         weight_vertical,
  input  wire logic [psr_pkg::WGT_W-1:0]         weight_source,
  input  wire logic [psr_pkg::RES_W-1:0]         tolerance,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [psr_pkg::DATA_W-1:0]      out_read_value,
  output logic [psr_pkg::CNT_W-1:0]              out_iterations_done,
  output logic                                   out_converged,
  output logic [psr_pkg::RES_W-1:0]              out_residual
);

  localparam int DW    = psr_pkg::DATA_W;
  localparam int SUM_W = DW + 1;
  localparam int PH_W  = psr_pkg::WGT_W + 1 + SUM_W;
  localparam int PS_W  = psr_pkg::WGT_W + 1 + DW;
  localparam int ACC_W = PH_W + 3;

  localparam logic signed [ACC_W-1:0] HALF =
    ACC_W'(1) << (psr_pkg::FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] QMAX =
    {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] QMIN = ~QMAX;
  localparam logic [SUM_W-1:0] RES_MAX =
    {{(SUM_W-psr_pkg::RES_W){1'b0}}, {psr_pkg::RES_W{1'b1}}};

  logic signed [DW-1:0] grid_rdata, next_rdata, src_rdata, grid_wdata;

  logic signed [DW-1:0]      left_r, up_r, old_r, nv_r;
  logic signed [SUM_W-1:0]   hsum_r, vsum_r;
  logic signed [PH_W-1:0]    ph_r, pv_r;
  logic signed [PS_W-1:0]    ps_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [psr_pkg::RES_W-1:0] diff_r, worst_r;

  logic signed [ACC_W-1:0] rnd_b, rnd_q;
  logic signed [DW-1:0]    nv_nxt;
  logic signed [SUM_W-1:0] d_s;
  logic [SUM_W-1:0]        d_abs;

  logic                      out_valid_r;
  logic signed [DW-1:0]      out_val_r;
  logic [psr_pkg::CNT_W-1:0] sweeps_r;
  logic                      conv_r;
  logic [psr_pkg::RES_W-1:0] resid_r;

  // grid write data source
  always_comb begin
    unique case (cmd.grid_wsel)
      psr_pkg::WS_INPUT: grid_wdata = in_cell_value;
      psr_pkg::WS_COPY:  grid_wdata = next_rdata;
      default:           grid_wdata = nv_r;
    endcase
  end

  psr_ram #(.WIDTH(DW), .DEPTH(psr_pkg::CELLS)) u_grid (
    .clk   (clk),
    .we    (cmd.grid_we),
    .waddr (cmd.cell_addr),
    .wdata (grid_wdata),
    .raddr (cmd.grid_raddr),
    .rdata (grid_rdata)
  );

  psr_ram #(.WIDTH(DW), .DEPTH(psr_pkg::CELLS)) u_src (
    .clk   (clk),
    .we    (cmd.src_we),
    .waddr (cmd.cell_addr),
    .wdata (in_source_term),
    .raddr (cmd.cell_addr),
    .rdata (src_rdata)
  );

  psr_ram #(.WIDTH(DW), .DEPTH(psr_pkg::CELLS)) u_next (
    .clk   (clk),
    .we    (cmd.next_we),
    .waddr (cmd.cell_addr),
    .wdata (nv_r),
    .raddr (cmd.cell_addr),
    .rdata (next_rdata)
  );

  // round to nearest, ties up, then saturate
  assign rnd_b = acc_r + HALF;
  assign rnd_q = rnd_b >>> psr_pkg::FRAC_BITS;
  always_comb begin
    if (rnd_q > QMAX) begin
      nv_nxt = QMAX[DW-1:0];
    end else if (rnd_q < QMIN) begin
      nv_nxt = QMIN[DW-1:0];
    end else begin
      nv_nxt = rnd_q[DW-1:0];
    end
  end

  // absolute change of the cell
  assign d_s   = SUM_W'(nv_r) - SUM_W'(old_r);
  assign d_abs = d_s[SUM_W-1] ? SUM_W'(-d_s) : SUM_W'(d_s);

  // stencil pipeline registers
  always_ff @(posedge clk) begin
    unique case (cmd.step)
      psr_pkg::STEP_LEFT:  left_r <= grid_rdata;
      psr_pkg::STEP_RIGHT: hsum_r <= SUM_W'(left_r) + SUM_W'(grid_rdata);
      psr_pkg::STEP_UP:    up_r   <= grid_rdata;
      psr_pkg::STEP_DOWN:  vsum_r <= SUM_W'(up_r) + SUM_W'(grid_rdata);
      psr_pkg::STEP_MUL: begin
        old_r <= grid_rdata;
        ph_r  <= $signed({1'b0, weight_horizontal}) * hsum_r;
        pv_r  <= $signed({1'b0, weight_vertical}) * vsum_r;
        ps_r  <= $signed({1'b0, weight_source}) * src_rdata;
      end
      psr_pkg::STEP_ADD:  acc_r  <= ACC_W'(ph_r) + ACC_W'(pv_r) - ACC_W'(ps_r);
      psr_pkg::STEP_RND:  nv_r   <= nv_nxt;
      psr_pkg::STEP_DIFF: diff_r <= (d_abs > RES_MAX) ? RES_MAX[psr_pkg::RES_W-1:0]
                                                      : d_abs[psr_pkg::RES_W-1:0];
      default: begin
      end
    endcase
  end

  // largest change of the sweep and status of the last solve
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worst_r  <= '0;
      sweeps_r <= '0;
      conv_r   <= 1'b0;
      resid_r  <= '0;
    end else begin
      if (cmd.worst_clr) begin
        worst_r <= '0;
      end else if ((cmd.step == psr_pkg::STEP_MAX) && (diff_r > worst_r)) begin
        worst_r <= diff_r;
      end
      if (cmd.status_ld) begin
        sweeps_r <= cmd.sweeps;
        conv_r   <= (worst_r <= tolerance);
        resid_r  <= worst_r;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_val_r <= cmd.out_rd ? grid_rdata : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_value      = out_val_r;
  assign out_iterations_done = sweeps_r;
  assign out_converged       = conv_r;
  assign out_residual        = resid_r;

  assign stat.out_busy   = out_valid_r && out_stall;
  assign stat.within_tol = (worst_r <= tolerance);

endmodule

`default_nettype wire
